/* design/lacf_pkg.sv */
// Package for the linear audio crossfade block: widths, register codes,
// payload structs and the control structs of the serial divider.
// No dependencies; used by every other file of the block.
`default_nettype none

package lacf_pkg;

  localparam int unsigned SAMPLE_WIDTH   = 16;
  localparam int unsigned POSITION_WIDTH = 24;
  localparam int unsigned MAX_CHANNELS   = 8;

  // Width of the channel_count register as the register map gives it.
  localparam int unsigned CHCFG_W  = 4;
  // Channel index width and a width that can hold MAX_CHANNELS itself.
  localparam int unsigned IDX_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CMP_W    = (CNT_W > CHCFG_W) ? CNT_W : CHCFG_W;

  // Product of a sample magnitude and a weight, and the sum of two products.
  localparam int unsigned PROD_W   = SAMPLE_WIDTH + POSITION_WIDTH;
  localparam int unsigned NUM_W    = PROD_W + 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = POSITION_WIDTH;

  localparam logic [POSITION_WIDTH-1:0] RESET_TOTAL    = POSITION_WIDTH'(48000);
  localparam logic [CHCFG_W-1:0]        RESET_CHANNELS = CHCFG_W'(2);
  localparam logic [POSITION_WIDTH-1:0] RESET_START    = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_FRAMES  = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_START_FRAME   = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DIV  = 4'b1000
  } xf_state_e;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_sample;
    logic signed [SAMPLE_WIDTH-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] mixed_sample;
    logic                           frame_end;
  } out_item_t;

  typedef struct packed {
    logic                      start;
    logic [NUM_W-1:0]          numerator;
    logic [POSITION_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [SAMPLE_WIDTH-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* design/lacf_serial_div.sv */
// Bit-serial restoring divider for the crossfade block: one quotient bit per cycle.
// Depends on lacf_pkg for widths and the request and response structs.
`default_nettype none

module lacf_serial_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lacf_pkg::div_req_t req_i,
  output lacf_pkg::div_rsp_t rsp_o
);

  localparam int unsigned SW  = lacf_pkg::SAMPLE_WIDTH;
  localparam int unsigned PW  = lacf_pkg::POSITION_WIDTH;
  localparam int unsigned CDW = $clog2(SW + 1);

  logic [PW-1:0]  rem_q;
  logic [SW-1:0]  shf_q;
  logic [PW-1:0]  dsr_q;
  logic [CDW-1:0] cnt_q;
  logic           busy_q;
  logic           done_q;

  logic [PW:0] trial;
  logic [PW:0] diff;
  logic        ge;

  // The quotient is known to fit in SW bits, so the upper numerator bits
  // already stand below the divisor and seed the remainder directly.
  assign trial = {rem_q, shf_q[SW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CDW'(SW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CDW'(1);
      if (cnt_q == CDW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.numerator[SW+PW-1:SW];
      shf_q <= req_i.numerator[SW-1:0];
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[PW-1:0] : trial[PW-1:0];
      shf_q <= {shf_q[SW-2:0], ge};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = shf_q;

endmodule

`default_nettype wire

/* design/linear_audio_crossfade.sv */
// Top level of the linear audio crossfade block: register file, frame counter,
// bit-serial multipliers and output register. Depends on lacf_pkg and lacf_serial_div.
`default_nettype none

// The block mixes interleaved samples of an outgoing (left) and an incoming
// (right) stream as (left*(T-c) + right*c)/T, truncated toward zero, where T is
// total_frames and c the frame position, which starts at start_frame, steps once
// after the last channel of every frame and saturates at T. A total_frames of zero
// acts as one, and channel_count is clamped to the range one to eight. Writing
// channel_count or start_frame restarts the frame at its first channel; writing
// start_frame also reloads the position. Registers must be written only while no item
// is in flight; the block itself does not enforce this. An item is accepted in the
// idle state, then passes through the two bit-serial multipliers, a step that
// combines the signed products, the bit-serial divider and the load of the output
// register, and the block takes no new item until that load is done. A finished item
// waits in the output register, and the next item is taken while it waits; a third
// item is taken only once the output register can accept the second.

module linear_audio_crossfade (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lacf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lacf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lacf_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lacf_pkg::out_item_t                 out_item_o
);

  localparam int unsigned SW   = lacf_pkg::SAMPLE_WIDTH;
  localparam int unsigned PW   = lacf_pkg::POSITION_WIDTH;
  localparam int unsigned PRW  = lacf_pkg::PROD_W;
  localparam int unsigned NW   = lacf_pkg::NUM_W;
  localparam int unsigned IW   = lacf_pkg::IDX_W;
  localparam int unsigned CW   = lacf_pkg::CMP_W;
  localparam int unsigned MCW  = $clog2(SW + 1);

  // Configuration registers and frame state.
  logic [PW-1:0]                  total_q;
  logic [lacf_pkg::CHCFG_W-1:0]   chan_q;
  logic [PW-1:0]                  pos_q;
  logic [IW-1:0]                  idx_q;

  lacf_pkg::xf_state_e            state_q, state_d;
  logic [MCW-1:0]                 mcnt_q;
  logic                           out_valid_q;

  // Datapath registers of the item in flight.
  logic [SW-1:0]                  lm_q, rm_q;
  logic                           ln_q, rn_q;
  logic [PW-1:0]                  wa_q, wb_q;
  logic [PRW-1:0]                 acc_a_q, acc_b_q;
  logic                           fend_q;
  logic                           neg_q;
  lacf_pkg::out_item_t            out_item_q;

  logic [PW-1:0]                  t_eff;
  logic [PW-1:0]                  c_eff;
  logic [CW-1:0]                  cc_eff;
  logic                           last_ch;
  logic                           in_acc;
  logic                           out_free;
  logic                           load_out;
  logic [SW-1:0]                  lmag, rmag;
  logic [NW-1:0]                  num;
  logic                           num_neg;
  lacf_pkg::div_req_t             div_req;
  lacf_pkg::div_rsp_t             div_rsp;

  // Effective length, position and channel count.
  assign t_eff = (total_q == '0) ? PW'(1) : total_q;
  assign c_eff = (pos_q < t_eff) ? pos_q : t_eff;

  always_comb begin
    if (chan_q == '0) begin
      cc_eff = CW'(1);
    end else if (CW'(chan_q) > CW'(lacf_pkg::MAX_CHANNELS)) begin
      cc_eff = CW'(lacf_pkg::MAX_CHANNELS);
    end else begin
      cc_eff = CW'(chan_q);
    end
  end

  // A stale index at or above the channel count also closes the frame.
  assign last_ch = ((CW'(idx_q) + CW'(1)) >= cc_eff);

  assign in_stall_o = (state_q != lacf_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == lacf_pkg::ST_DIV) && div_rsp.done && out_free;

  // Sign and magnitude of the inputs; the most negative value maps onto
  // its magnitude as an unsigned number.
  assign lmag = in_item_i.left_sample[SW-1]  ? (~in_item_i.left_sample + SW'(1))
                                              : in_item_i.left_sample;
  assign rmag = in_item_i.right_sample[SW-1] ? (~in_item_i.right_sample + SW'(1))
                                              : in_item_i.right_sample;

  // Combine the two weighted magnitudes into one signed magnitude.
  always_comb begin
    if (ln_q == rn_q) begin
      num     = NW'(acc_a_q) + NW'(acc_b_q);
      num_neg = ln_q;
    end else if (acc_a_q >= acc_b_q) begin
      num     = NW'(acc_a_q - acc_b_q);
      num_neg = ln_q;
    end else begin
      num     = NW'(acc_b_q - acc_a_q);
      num_neg = rn_q;
    end
  end

  always_comb begin
    div_req.start     = (state_q == lacf_pkg::ST_SUM);
    div_req.numerator = num;
    div_req.divisor   = t_eff;
  end

  lacf_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lacf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = lacf_pkg::ST_MUL;
        end
      end
      lacf_pkg::ST_MUL: begin
        if (mcnt_q == MCW'(1)) begin
          state_d = lacf_pkg::ST_SUM;
        end
      end
      lacf_pkg::ST_SUM: begin
        state_d = lacf_pkg::ST_DIV;
      end
      lacf_pkg::ST_DIV: begin
        if (load_out) begin
          state_d = lacf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lacf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lacf_pkg::ST_IDLE;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
      total_q     <= lacf_pkg::RESET_TOTAL;
      chan_q      <= lacf_pkg::RESET_CHANNELS;
      pos_q       <= lacf_pkg::RESET_START;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;

      if (in_acc) begin
        mcnt_q <= MCW'(SW);
      end else if (state_q == lacf_pkg::ST_MUL) begin
        mcnt_q <= mcnt_q - MCW'(1);
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // The frame counter steps at accept time; the weights of the item
      // were already captured from the old position.
      if (in_acc) begin
        if (last_ch) begin
          idx_q <= '0;
          pos_q <= (c_eff < t_eff) ? (c_eff + PW'(1)) : t_eff;
        end else begin
          idx_q <= idx_q + IW'(1);
        end
      end

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          lacf_pkg::CFG_TOTAL_FRAMES: begin
            total_q <= cfg_data_i[PW-1:0];
          end
          lacf_pkg::CFG_CHANNEL_COUNT: begin
            chan_q <= cfg_data_i[lacf_pkg::CHCFG_W-1:0];
            idx_q  <= '0;
          end
          lacf_pkg::CFG_START_FRAME: begin
            pos_q <= cfg_data_i[PW-1:0];
            idx_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Multiplier bits enter MSB first, so each product grows by a shift and an add.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lm_q    <= lmag;
      rm_q    <= rmag;
      ln_q    <= in_item_i.left_sample[SW-1];
      rn_q    <= in_item_i.right_sample[SW-1];
      wa_q    <= t_eff - c_eff;
      wb_q    <= c_eff;
      acc_a_q <= '0;
      acc_b_q <= '0;
      fend_q  <= last_ch;
    end else if (state_q == lacf_pkg::ST_MUL) begin
      acc_a_q <= {acc_a_q[PRW-2:0], 1'b0} + (lm_q[SW-1] ? PRW'(wa_q) : '0);
      acc_b_q <= {acc_b_q[PRW-2:0], 1'b0} + (rm_q[SW-1] ? PRW'(wb_q) : '0);
      lm_q    <= {lm_q[SW-2:0], 1'b0};
      rm_q    <= {rm_q[SW-2:0], 1'b0};
    end

    if (state_q == lacf_pkg::ST_SUM) begin
      neg_q <= num_neg;
    end

    if (load_out) begin
      out_item_q.mixed_sample <= neg_q ? (SW'(0) - div_rsp.quotient) : div_rsp.quotient;
      out_item_q.frame_end    <= fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A finished quotient is moved out as soon as the output register frees up.
  a_load_returns_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (state_q == lacf_pkg::ST_IDLE) && out_valid_q)
    else $error("output load did not return the sequencer to idle");

  // A new result only appears after the divider phase.
  a_result_after_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == lacf_pkg::ST_DIV) && $past(div_rsp.done))
    else $error("result raised outside the divider phase");

  // The divider never runs while the block is idle or multiplying.
  a_div_busy_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == lacf_pkg::ST_DIV))
    else $error("divider busy outside the divider phase");

  // The channel index stays within the supported channel count.
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(idx_q) < CW'(lacf_pkg::MAX_CHANNELS)))
    else $error("channel index out of range");

endmodule

`default_nettype wire
